// ===== src/eia_pkg.sv =====
// Shared types, codes and defaults for the entity ID allocator.
package eia_pkg;

  localparam int NUM_IDS_DEF       = 256;
  localparam int PENDING_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF      = 8;

  localparam logic [2:0] REQ_CREATE  = 3'd0;
  localparam logic [2:0] REQ_DELETE  = 3'd1;
  localparam logic [2:0] REQ_SET_TAG = 3'd2;
  localparam logic [2:0] REQ_QUERY   = 3'd3;
  localparam logic [2:0] REQ_COMMIT  = 3'd4;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE_ID   = 2'd1;
  localparam logic [1:0] STATUS_PENDING_FULL = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] entity_id;
    logic [7:0] tag_in;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] id_out;
    logic       handle_valid;
    logic [7:0] tag_out;
    logic       is_alive;
    logic       removal_notice;
    logic       notice_target;
    logic       was_freed;
    logic       last;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_NOFREE,
    S_ZERO,
    S_CR_RD,
    S_CR_WR,
    S_EN_RD,
    S_EN_OUT,
    S_P0_RD,
    S_P0_ENT,
    S_P0_WR,
    S_P1_RD,
    S_P1_OUT
  } state_t;

  typedef enum logic [2:0] {
    OK_NONE,
    OK_CREATE,
    OK_NOFREE,
    OK_ENTRY,
    OK_NOTICE0,
    OK_NOTICE1,
    OK_ZERO
  } out_kind_t;

  typedef struct packed {
    logic      clr_step;
    logic      latch;
    logic      pop;
    logic      ent_rd;
    logic      pend_rd;
    logic      pend_ent;
    logic      cidx_inc;
    logic      cidx_clr;
    logic      pend_clr;
    out_kind_t out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic stack_empty;
    logic pend_empty;
    logic cidx_last;
  } dp_sts_t;

endpackage

// ===== src/entity_id_allocator.sv =====
// Entity ID allocator: LIFO free stack of IDs with alive bits, tags and deferred deletes.
// Create with a free ID reads the stack and then writes the entity; delete, set tag and query
// read the entity and then give the result. Commit runs a freeing pass through the pending,
// entity and stack memories, then a second notice pass that reads the pending memory.
// Create with no free ID, empty commit and unknown requests go straight to the result; busy falls with the result.
// After reset busy stays high while the entity memory is cleared.
module entity_id_allocator #(
  parameter int NUM_IDS       = eia_pkg::NUM_IDS_DEF,
  parameter int PENDING_DEPTH = eia_pkg::PENDING_DEPTH_DEF,
  parameter int TAG_BITS      = eia_pkg::TAG_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  eia_pkg::in_t  in_data,
  output logic          out_valid,
  output eia_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata
);

  eia_pkg::dp_cmd_t cmd;
  eia_pkg::dp_sts_t sts;

  eia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_data.req_type),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  eia_dp #(
    .NUM_IDS       (NUM_IDS),
    .PENDING_DEPTH (PENDING_DEPTH),
    .TAG_BITS      (TAG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Only the final transfer of a request may appear once the block is idle.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> busy)
    else $error("non-final result while idle");

  // A final result is never directly followed by another result.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("result right after a final result");

endmodule

// ===== src/eia_ram.sv =====
// Generic single-port-write, registered-read RAM.
module eia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/eia_ctrl.sv =====
// Controller state machine that sequences every request through the datapath.
module eia_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [2:0]       req_type,
  input  eia_pkg::dp_sts_t sts,
  output logic             busy,
  output eia_pkg::dp_cmd_t cmd
);

  eia_pkg::state_t state_r;
  eia_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eia_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.out_kind = eia_pkg::OK_NONE;
    case (state_r)
      eia_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = eia_pkg::S_IDLE;
        end
      end
      eia_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (req_type == eia_pkg::REQ_CREATE) begin
            state_nxt = sts.stack_empty ? eia_pkg::S_NOFREE : eia_pkg::S_CR_RD;
          end else if (req_type inside {eia_pkg::REQ_DELETE, eia_pkg::REQ_SET_TAG,
                                        eia_pkg::REQ_QUERY}) begin
            state_nxt = eia_pkg::S_EN_RD;
          end else if (req_type == eia_pkg::REQ_COMMIT) begin
            state_nxt = sts.pend_empty ? eia_pkg::S_ZERO : eia_pkg::S_P0_RD;
          end else begin
            state_nxt = eia_pkg::S_ZERO;
          end
        end
      end
      eia_pkg::S_NOFREE: begin
        cmd.out_kind = eia_pkg::OK_NOFREE;
        state_nxt    = eia_pkg::S_IDLE;
      end
      eia_pkg::S_ZERO: begin
        cmd.out_kind = eia_pkg::OK_ZERO;
        state_nxt    = eia_pkg::S_IDLE;
      end
      eia_pkg::S_CR_RD: begin
        cmd.pop   = 1'b1;
        state_nxt = eia_pkg::S_CR_WR;
      end
      eia_pkg::S_CR_WR: begin
        cmd.out_kind = eia_pkg::OK_CREATE;
        state_nxt    = eia_pkg::S_IDLE;
      end
      eia_pkg::S_EN_RD: begin
        cmd.ent_rd = 1'b1;
        state_nxt  = eia_pkg::S_EN_OUT;
      end
      eia_pkg::S_EN_OUT: begin
        cmd.out_kind = eia_pkg::OK_ENTRY;
        state_nxt    = eia_pkg::S_IDLE;
      end
      eia_pkg::S_P0_RD: begin
        cmd.pend_rd = 1'b1;
        state_nxt   = eia_pkg::S_P0_ENT;
      end
      eia_pkg::S_P0_ENT: begin
        cmd.pend_ent = 1'b1;
        state_nxt    = eia_pkg::S_P0_WR;
      end
      eia_pkg::S_P0_WR: begin
        cmd.out_kind = eia_pkg::OK_NOTICE0;
        if (sts.cidx_last) begin
          cmd.cidx_clr = 1'b1;
          state_nxt    = eia_pkg::S_P1_RD;
        end else begin
          cmd.cidx_inc = 1'b1;
          state_nxt    = eia_pkg::S_P0_RD;
        end
      end
      eia_pkg::S_P1_RD: begin
        cmd.pend_rd = 1'b1;
        state_nxt   = eia_pkg::S_P1_OUT;
      end
      eia_pkg::S_P1_OUT: begin
        cmd.out_kind = eia_pkg::OK_NOTICE1;
        if (sts.cidx_last) begin
          cmd.cidx_clr = 1'b1;
          cmd.pend_clr = 1'b1;
          state_nxt    = eia_pkg::S_IDLE;
        end else begin
          cmd.cidx_inc = 1'b1;
          state_nxt    = eia_pkg::S_P1_RD;
        end
      end
      default: begin
        state_nxt = eia_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != eia_pkg::S_IDLE);

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not make the block busy");

endmodule

// ===== src/eia_dp.sv =====
// Datapath: entity, free stack and pending memories, counters and result register.
module eia_dp #(
  parameter int NUM_IDS       = eia_pkg::NUM_IDS_DEF,
  parameter int PENDING_DEPTH = eia_pkg::PENDING_DEPTH_DEF,
  parameter int TAG_BITS      = eia_pkg::TAG_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  eia_pkg::in_t     in_data,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  eia_pkg::dp_cmd_t cmd,
  output eia_pkg::dp_sts_t sts,
  output logic             out_valid,
  output eia_pkg::out_t    out_data
);

  localparam int IdW   = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int CntW  = $clog2(NUM_IDS + 1);
  localparam int PidxW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PcntW = $clog2(PENDING_DEPTH + 1);
  localparam int EntW  = TAG_BITS + 1;

  logic [2:0]          req_r;
  logic [7:0]          id_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [TAG_BITS-1:0] dtag_r;
  logic [CntW-1:0]     fc_r;
  logic [CntW-1:0]     lw_r;
  logic                fresh_r;
  logic [IdW-1:0]      fresh_id_r;
  logic [PcntW-1:0]    pcnt_r;
  logic [PidxW-1:0]    cidx_r;
  logic [PENDING_DEPTH-1:0] freed_r;
  logic [IdW-1:0]      pid_r;
  logic [IdW-1:0]      clr_addr_r;
  logic                out_valid_r;
  eia_pkg::out_t       out_r;
  logic                out_valid_nxt;
  eia_pkg::out_t       out_nxt;

  logic                ent_we;
  logic [IdW-1:0]      ent_waddr;
  logic [EntW-1:0]     ent_wdata;
  logic                ent_re;
  logic [IdW-1:0]      ent_raddr;
  logic [EntW-1:0]     ent_rdata;
  logic                stk_we;
  logic [IdW-1:0]      stk_rdata;
  logic                pnd_we;
  logic [IdW-1:0]      pnd_rdata;

  logic                inr;
  logic [IdW-1:0]      id_idx;
  logic                ent_alive;
  logic                al;
  logic [IdW-1:0]      nid;
  logic                pfull;
  logic                is_create;
  logic                is_entry;
  logic                is_notice0;

  assign inr        = (32'(id_r) < NUM_IDS);
  assign id_idx     = IdW'(id_r);
  assign ent_alive  = ent_rdata[TAG_BITS];
  assign al         = inr & ent_alive;
  assign nid        = fresh_r ? fresh_id_r : stk_rdata;
  assign pfull      = (pcnt_r == PcntW'(PENDING_DEPTH));
  assign is_create  = (cmd.out_kind == eia_pkg::OK_CREATE);
  assign is_entry   = (cmd.out_kind == eia_pkg::OK_ENTRY);
  assign is_notice0 = (cmd.out_kind == eia_pkg::OK_NOTICE0);

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = clr_addr_r;
    ent_wdata = '0;
    ent_re    = 1'b0;
    ent_raddr = id_idx;
    if (cmd.clr_step) begin
      ent_we = 1'b1;
    end
    if (is_create) begin
      ent_we    = 1'b1;
      ent_waddr = nid;
      ent_wdata = {1'b1, tag_r};
    end
    if (is_entry && (req_r == eia_pkg::REQ_SET_TAG) && inr) begin
      ent_we    = 1'b1;
      ent_waddr = id_idx;
      ent_wdata = {ent_alive, tag_r};
    end
    if (is_notice0 && ent_alive) begin
      ent_we    = 1'b1;
      ent_waddr = pid_r;
      ent_wdata = {1'b0, dtag_r};
    end
    if (cmd.ent_rd) begin
      ent_re = 1'b1;
    end
    if (cmd.pend_ent) begin
      ent_re    = 1'b1;
      ent_raddr = pnd_rdata;
    end
  end

  assign stk_we = is_notice0 && ent_alive && (fc_r < CntW'(NUM_IDS));
  assign pnd_we = is_entry && (req_r == eia_pkg::REQ_DELETE) && !pfull && inr;

  eia_ram #(.WIDTH(EntW), .DEPTH(NUM_IDS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  eia_ram #(.WIDTH(IdW), .DEPTH(NUM_IDS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (IdW'(fc_r)),
    .wdata (pid_r),
    .re    (cmd.pop),
    .raddr (IdW'(fc_r - CntW'(1))),
    .rdata (stk_rdata)
  );

  eia_ram #(.WIDTH(IdW), .DEPTH(PENDING_DEPTH)) u_pend_ram (
    .clk   (clk),
    .we    (pnd_we),
    .waddr (PidxW'(pcnt_r)),
    .wdata (id_idx),
    .re    (cmd.pend_rd),
    .raddr (cidx_r),
    .rdata (pnd_rdata)
  );

  // Stack slots below the low-water mark were never pushed, so a pop there returns
  // the ID in the reset order, computed from the count, rather than the RAM word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= CntW'(NUM_IDS);
      lw_r        <= CntW'(NUM_IDS);
      pcnt_r      <= '0;
      cidx_r      <= '0;
      clr_addr_r  <= '0;
      dtag_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dtag_r <= TAG_BITS'(cfg_wdata);
      end
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + IdW'(1);
      end
      if (cmd.pop) begin
        fc_r <= fc_r - CntW'(1);
        if (fc_r == lw_r) begin
          lw_r <= lw_r - CntW'(1);
        end
      end else if (stk_we) begin
        fc_r <= fc_r + CntW'(1);
      end
      if (cmd.pend_clr) begin
        pcnt_r <= '0;
      end else if (pnd_we) begin
        pcnt_r <= pcnt_r + PcntW'(1);
      end
      if (cmd.cidx_clr) begin
        cidx_r <= '0;
      end else if (cmd.cidx_inc) begin
        cidx_r <= cidx_r + PidxW'(1);
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_data.req_type;
      id_r  <= in_data.entity_id;
      tag_r <= TAG_BITS'(in_data.tag_in);
    end
    if (cmd.pop) begin
      fresh_r    <= (fc_r == lw_r);
      fresh_id_r <= IdW'(CntW'(NUM_IDS) - fc_r);
    end
    if (cmd.pend_ent) begin
      pid_r <= pnd_rdata;
    end
    if (is_notice0) begin
      freed_r[cidx_r] <= ent_alive;
    end
    out_r <= out_nxt;
  end

  always_comb begin
    out_nxt       = '0;
    out_valid_nxt = (cmd.out_kind != eia_pkg::OK_NONE);
    case (cmd.out_kind)
      eia_pkg::OK_CREATE: begin
        out_nxt.status       = eia_pkg::STATUS_OK;
        out_nxt.id_out       = 8'(nid);
        out_nxt.handle_valid = 1'b1;
        out_nxt.last         = 1'b1;
      end
      eia_pkg::OK_NOFREE: begin
        out_nxt.status = eia_pkg::STATUS_NO_FREE_ID;
        out_nxt.last   = 1'b1;
      end
      eia_pkg::OK_ENTRY: begin
        out_nxt.id_out       = id_r;
        out_nxt.handle_valid = al;
        out_nxt.last         = 1'b1;
        case (req_r)
          eia_pkg::REQ_DELETE: begin
            out_nxt.status = pfull ? eia_pkg::STATUS_PENDING_FULL : eia_pkg::STATUS_OK;
          end
          eia_pkg::REQ_SET_TAG: begin
            out_nxt.tag_out  = inr ? 8'(tag_r) : 8'd0;
            out_nxt.is_alive = al;
          end
          eia_pkg::REQ_QUERY: begin
            out_nxt.tag_out  = inr ? 8'(ent_rdata[TAG_BITS-1:0]) : 8'd0;
            out_nxt.is_alive = al;
          end
          default: begin
            out_nxt.status = eia_pkg::STATUS_OK;
          end
        endcase
      end
      eia_pkg::OK_NOTICE0: begin
        out_nxt.id_out         = 8'(pid_r);
        out_nxt.removal_notice = 1'b1;
        out_nxt.was_freed      = ent_alive;
      end
      eia_pkg::OK_NOTICE1: begin
        out_nxt.id_out         = 8'(pnd_rdata);
        out_nxt.removal_notice = 1'b1;
        out_nxt.notice_target  = 1'b1;
        out_nxt.was_freed      = freed_r[cidx_r];
        out_nxt.last           = sts.cidx_last;
      end
      eia_pkg::OK_ZERO: begin
        out_nxt.last = 1'b1;
      end
      default: begin
        out_nxt.status = eia_pkg::STATUS_OK;
      end
    endcase
  end

  assign sts.clr_last    = (clr_addr_r == IdW'(NUM_IDS - 1));
  assign sts.stack_empty = (fc_r == '0);
  assign sts.pend_empty  = (pcnt_r == '0);
  assign sts.cidx_last   = ((PcntW'(cidx_r) + PcntW'(1)) == pcnt_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The low-water mark never rises above the free count.
  a_lw_below_fc: assert property (@(posedge clk) disable iff (!rst_n)
    lw_r <= fc_r)
    else $error("free stack low-water mark above free count");

  // The free count never exceeds the number of IDs.
  a_fc_range: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CntW'(NUM_IDS))
    else $error("free count exceeds the number of IDs");

  // The pending list never holds more entries than it has room for.
  a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PcntW'(PENDING_DEPTH))
    else $error("pending count exceeds pending depth");

endmodule

// ===== test/entity_id_allocator_tb.sv =====
// Self-checking testbench for the entity ID allocator with a built-in allocator model.
module entity_id_allocator_tb;

  localparam int NUM_IDS    = eia_pkg::NUM_IDS_DEF;
  localparam int PEND_DEPTH = eia_pkg::PENDING_DEPTH_DEF;
  localparam int STALL_MAX  = 4000;

  typedef enum {MIX_OPS, FILL_IDS, PURGE_IDS} stim_mode_t;

  typedef struct {
    eia_pkg::in_t  req;
    bit            pinned;
    eia_pkg::out_t want;
  } dir_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  eia_pkg::in_t  in_data = '0;
  logic          out_valid;
  eia_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic [7:0]    cfg_wdata = 8'h00;

  logic          pin_v = 1'b0;
  eia_pkg::out_t pin_r = '0;

  logic [7:0] id_stack [NUM_IDS];
  logic       id_alive [NUM_IDS];
  logic [7:0] id_tag   [NUM_IDS];
  logic [7:0] pend_ids [PEND_DEPTH];
  int         free_cnt;
  int         pend_cnt;
  logic [7:0] dflt_tag;

  eia_pkg::out_t step_res [$];
  eia_pkg::out_t result_q [$];
  dir_row_t      dir_tab  [$];
  int            err_cnt = 0;
  int            stall_cnt = 0;
  int            burst_left = 0;

  entity_id_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_err(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic cmp_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_err($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic check_result(eia_pkg::out_t got);
    eia_pkg::out_t w;
    if (result_q.size() == 0) begin
      report_err($sformatf("result %h arrived with nothing expected", got));
      return;
    end
    w = result_q.pop_front();
    cmp_field("status", 8'(got.status), 8'(w.status));
    cmp_field("id_out", got.id_out, w.id_out);
    cmp_field("handle_valid", 8'(got.handle_valid), 8'(w.handle_valid));
    cmp_field("tag_out", got.tag_out, w.tag_out);
    cmp_field("is_alive", 8'(got.is_alive), 8'(w.is_alive));
    cmp_field("removal_notice", 8'(got.removal_notice), 8'(w.removal_notice));
    cmp_field("notice_target", 8'(got.notice_target), 8'(w.notice_target));
    cmp_field("was_freed", 8'(got.was_freed), 8'(w.was_freed));
    cmp_field("last", 8'(got.last), 8'(w.last));
  endtask

  // Advances the allocator state by one request and leaves its results in step_res.
  task automatic apply_request(eia_pkg::in_t it);
    eia_pkg::out_t         r;
    logic                  al;
    logic [7:0]            p;
    logic [PEND_DEPTH-1:0] freed;
    step_res.delete();
    al = (it.entity_id < NUM_IDS) ? id_alive[it.entity_id] : 1'b0;
    r = '0;
    r.last = 1'b1;
    case (it.req_type)
      eia_pkg::REQ_CREATE: begin
        if (free_cnt == 0) begin
          r.status = eia_pkg::STATUS_NO_FREE_ID;
        end else begin
          free_cnt--;
          p = id_stack[free_cnt];
          id_alive[p] = 1'b1;
          id_tag[p] = it.tag_in;
          r.id_out = p;
          r.handle_valid = 1'b1;
        end
        step_res = {step_res, r};
      end
      eia_pkg::REQ_DELETE: begin
        r.id_out = it.entity_id;
        r.handle_valid = al;
        if (pend_cnt >= PEND_DEPTH) begin
          r.status = eia_pkg::STATUS_PENDING_FULL;
        end else if (it.entity_id < NUM_IDS) begin
          pend_ids[pend_cnt] = it.entity_id;
          pend_cnt++;
        end
        step_res = {step_res, r};
      end
      eia_pkg::REQ_SET_TAG, eia_pkg::REQ_QUERY: begin
        if (it.req_type == eia_pkg::REQ_SET_TAG && it.entity_id < NUM_IDS) begin
          id_tag[it.entity_id] = it.tag_in;
        end
        r.id_out = it.entity_id;
        r.handle_valid = al;
        r.is_alive = al;
        r.tag_out = (it.entity_id < NUM_IDS) ? id_tag[it.entity_id] : 8'h00;
        step_res = {step_res, r};
      end
      eia_pkg::REQ_COMMIT: begin
        if (pend_cnt == 0) begin
          step_res = {step_res, r};
        end else begin
          for (int i = 0; i < pend_cnt; i++) begin
            p = pend_ids[i];
            freed[i] = 1'b0;
            if (p < NUM_IDS && id_alive[p]) begin
              if (free_cnt < NUM_IDS) begin
                id_stack[free_cnt] = p;
                free_cnt++;
              end
              id_alive[p] = 1'b0;
              id_tag[p] = dflt_tag;
              freed[i] = 1'b1;
            end
            r = '0;
            r.id_out = p;
            r.removal_notice = 1'b1;
            r.was_freed = freed[i];
            step_res = {step_res, r};
          end
          for (int i = 0; i < pend_cnt; i++) begin
            r = '0;
            r.id_out = pend_ids[i];
            r.removal_notice = 1'b1;
            r.notice_target = 1'b1;
            r.was_freed = freed[i];
            r.last = (i == pend_cnt - 1);
            step_res = {step_res, r};
          end
          pend_cnt = 0;
        end
      end
      default: step_res = {step_res, r};
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) check_result(out_data);
      if (start === 1'b1 && busy === 1'b0) begin
        apply_request(in_data);
        if (pin_v) begin
          result_q = {result_q, pin_r};
        end else begin
          result_q = {result_q, step_res};
        end
      end
      if (cfg_we === 1'b1) dflt_tag = cfg_wdata;
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt == STALL_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic eia_pkg::in_t mk_req(logic [2:0] req, logic [7:0] id, logic [7:0] tag);
    eia_pkg::in_t it;
    it.req_type = req;
    it.entity_id = id;
    it.tag_in = tag;
    return it;
  endfunction

  function automatic eia_pkg::out_t mk_res(logic [1:0] st, logic [7:0] id, logic hv,
                                           logic [7:0] tag, logic al);
    eia_pkg::out_t r;
    r = '0;
    r.status = st;
    r.id_out = id;
    r.handle_valid = hv;
    r.tag_out = tag;
    r.is_alive = al;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic add_row(eia_pkg::in_t req, bit pinned, eia_pkg::out_t want);
    dir_row_t row;
    row.req = req;
    row.pinned = pinned;
    row.want = want;
    dir_tab = {dir_tab, row};
  endtask

  function automatic logic [7:0] pick_id(bit want_alive);
    int base;
    base = $urandom_range(0, NUM_IDS - 1);
    if (want_alive) begin
      for (int k = 0; k < NUM_IDS; k++) begin
        if (id_alive[(base + k) % NUM_IDS]) return 8'((base + k) % NUM_IDS);
      end
    end
    return 8'(base);
  endfunction

  function automatic eia_pkg::in_t next_request(stim_mode_t m);
    eia_pkg::in_t it;
    int           roll;
    it.req_type = eia_pkg::REQ_QUERY;
    it.entity_id = 8'($urandom_range(0, 255));
    it.tag_in = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    case (m)
      FILL_IDS: begin
        if (roll < 85) begin
          it.req_type = eia_pkg::REQ_CREATE;
        end else if (roll < 92) begin
          it.req_type = eia_pkg::REQ_SET_TAG;
          it.entity_id = pick_id(1'b1);
        end else begin
          it.entity_id = pick_id(roll[0]);
        end
      end
      PURGE_IDS: begin
        if (pend_cnt >= PEND_DEPTH && roll < 50) begin
          it.req_type = eia_pkg::REQ_COMMIT;
        end else if (roll < 60) begin
          it.req_type = eia_pkg::REQ_DELETE;
          it.entity_id = pick_id(1'b1);
        end else if (roll < 72) begin
          it.req_type = eia_pkg::REQ_DELETE;
        end else if (roll < 77) begin
          it.req_type = eia_pkg::REQ_COMMIT;
        end else if (roll < 90) begin
          it.entity_id = pick_id(roll[0]);
        end else begin
          it.req_type = eia_pkg::REQ_CREATE;
        end
      end
      default: begin
        if (roll < 28) begin
          it.req_type = eia_pkg::REQ_CREATE;
        end else if (roll < 50) begin
          it.req_type = eia_pkg::REQ_DELETE;
          it.entity_id = pick_id(1'b1);
        end else if (roll < 55) begin
          it.req_type = eia_pkg::REQ_DELETE;
        end else if (roll < 63) begin
          it.req_type = eia_pkg::REQ_SET_TAG;
          it.entity_id = pick_id(roll < 60);
        end else if (roll < 75) begin
          it.entity_id = pick_id(roll[0]);
        end else if (roll < 88) begin
          it.req_type = eia_pkg::REQ_COMMIT;
        end else if (roll < 95) begin
          it.req_type = 3'($urandom_range(5, 7));
        end else begin
          it.req_type = eia_pkg::REQ_DELETE;
        end
      end
    endcase
    return it;
  endfunction

  // Holds the request until the transfer, then idles in bursts; the extra edge lets the
  // model settle before the next request is built from its state.
  task automatic drive(eia_pkg::in_t it, bit pinned, eia_pkg::out_t want);
    start <= 1'b1;
    in_data <= it;
    pin_v <= pinned;
    pin_r <= want;
    do @(posedge clk); while (busy !== 1'b0);
    start <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end else begin
      burst_left--;
    end
    @(posedge clk);
  endtask

  task automatic write_default_tag(logic [7:0] v);
    while (result_q.size() != 0) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int nofree_seen;
    for (int i = 0; i < NUM_IDS; i++) begin
      id_stack[i] = 8'(NUM_IDS - 1 - i);
      id_alive[i] = 1'b0;
      id_tag[i] = 8'h00;
    end
    free_cnt = NUM_IDS;
    pend_cnt = 0;
    dflt_tag = 8'h00;

    add_row(mk_req(eia_pkg::REQ_QUERY, 8'h00, 8'h00), 1,
            mk_res(eia_pkg::STATUS_OK, 8'h00, 0, 8'h00, 0));
    add_row(mk_req(eia_pkg::REQ_QUERY, 8'hFF, 8'hFF), 1,
            mk_res(eia_pkg::STATUS_OK, 8'hFF, 0, 8'h00, 0));
    add_row(mk_req(eia_pkg::REQ_COMMIT, 8'h00, 8'h00), 1,
            mk_res(eia_pkg::STATUS_OK, 8'h00, 0, 8'h00, 0));
    add_row(mk_req(eia_pkg::REQ_CREATE, 8'h00, 8'hFF), 1,
            mk_res(eia_pkg::STATUS_OK, 8'h00, 1, 8'h00, 0));
    add_row(mk_req(eia_pkg::REQ_CREATE, 8'hFF, 8'h00), 1,
            mk_res(eia_pkg::STATUS_OK, 8'h01, 1, 8'h00, 0));
    add_row(mk_req(eia_pkg::REQ_QUERY, 8'h00, 8'h00), 1,
            mk_res(eia_pkg::STATUS_OK, 8'h00, 1, 8'hFF, 1));
    add_row(mk_req(eia_pkg::REQ_SET_TAG, 8'h01, 8'hAB), 1,
            mk_res(eia_pkg::STATUS_OK, 8'h01, 1, 8'hAB, 1));
    add_row(mk_req(eia_pkg::REQ_SET_TAG, 8'hFF, 8'h81), 1,
            mk_res(eia_pkg::STATUS_OK, 8'hFF, 0, 8'h81, 0));
    add_row(mk_req(3'd5, 8'h00, 8'h00), 1,
            mk_res(eia_pkg::STATUS_OK, 8'h00, 0, 8'h00, 0));
    add_row(mk_req(3'd7, 8'hFF, 8'hFF), 1,
            mk_res(eia_pkg::STATUS_OK, 8'h00, 0, 8'h00, 0));
    add_row(mk_req(eia_pkg::REQ_DELETE, 8'h00, 8'h00), 1,
            mk_res(eia_pkg::STATUS_OK, 8'h00, 1, 8'h00, 0));
    add_row(mk_req(eia_pkg::REQ_DELETE, 8'h00, 8'hFF), 1,
            mk_res(eia_pkg::STATUS_OK, 8'h00, 1, 8'h00, 0));
    add_row(mk_req(eia_pkg::REQ_DELETE, 8'hFF, 8'h00), 1,
            mk_res(eia_pkg::STATUS_OK, 8'hFF, 0, 8'h00, 0));
    add_row(mk_req(eia_pkg::REQ_DELETE, 8'h01, 8'h00), 0, '0);
    add_row(mk_req(eia_pkg::REQ_COMMIT, 8'h00, 8'h00), 0, '0);
    add_row(mk_req(eia_pkg::REQ_QUERY, 8'h00, 8'h00), 0, '0);
    add_row(mk_req(eia_pkg::REQ_QUERY, 8'hFF, 8'h00), 0, '0);
    add_row(mk_req(eia_pkg::REQ_CREATE, 8'h00, 8'h3C), 0, '0);
    add_row(mk_req(eia_pkg::REQ_CREATE, 8'h00, 8'hC3), 0, '0);
    add_row(mk_req(3'd6, 8'h5A, 8'hA5), 1,
            mk_res(eia_pkg::STATUS_OK, 8'h00, 0, 8'h00, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_default_tag(8'h5A);
    foreach (dir_tab[i]) drive(dir_tab[i].req, dir_tab[i].pinned, dir_tab[i].want);

    write_default_tag(8'h00);
    repeat (100) drive(next_request(MIX_OPS), 0, '0);

    write_default_tag(8'hFF);
    nofree_seen = 0;
    while (nofree_seen < 8) begin
      if (free_cnt == 0) nofree_seen++;
      drive(next_request(FILL_IDS), 0, '0);
    end

    write_default_tag(8'($urandom_range(1, 254)));
    repeat (80) drive(next_request(PURGE_IDS), 0, '0);
    drive(mk_req(eia_pkg::REQ_COMMIT, 8'h00, 8'h00), 0, '0);

    while (result_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/eia_pkg.sv
src/eia_ram.sv
src/eia_ctrl.sv
src/eia_dp.sv
src/entity_id_allocator.sv
test/entity_id_allocator_tb.sv
